### design/bppc_pkg.sv
`default_nettype none

package bppc_pkg;

  localparam int PIXELS_PER_WORD = 32;
  localparam int PALETTE_ENTRIES = 16;
  localparam int PLANE_BITS      = 32;
  localparam int INDEX_BITS      = 4;
  localparam int COLOR_BITS      = 12;

  localparam logic MODE_PALETTE = 1'b0;
  localparam logic MODE_PLANES  = 1'b1;

  // bit-reversed and inverted nibble
  localparam logic [3:0] NIBBLE_FLIP [16] = '{
    4'hF, 4'h7, 4'hB, 4'h3, 4'hD, 4'h5, 4'h9, 4'h1,
    4'hE, 4'h6, 4'hA, 4'h2, 4'hC, 4'h4, 4'h8, 4'h0
  };

  // one slot leaving the serializer: a palette write or one pixel index
  typedef struct packed {
    logic                  write;
    logic [INDEX_BITS-1:0] idx;
    logic [COLOR_BITS-1:0] word;
    logic                  last;
  } bppc_slot_t;

  function automatic logic [7:0] nibble_level(input logic [3:0] nib);
    logic [3:0] flip;
    logic [7:0] lvl;
    flip = NIBBLE_FLIP[nib];
    unique case (flip[3:2])
      2'd0:    lvl = 8'd0;
      2'd1:    lvl = 8'd127;
      2'd2:    lvl = 8'd191;
      default: lvl = 8'd255;
    endcase
    return lvl;
  endfunction

endpackage

`default_nettype wire

### design/bitplane_palette_pixel_converter.sv
`default_nettype none
// Channel  Dir  Handshake          Payload
// in       in   in_valid/in_stall  mode, palette_index, palette_word, plane_zero..three
// out      out  out_valid/out_stall red, green, blue, last_pixel
//
// A plane item gives PIXELS_PER_WORD pixels, one per cycle unless out_stall holds;
// the plane serializer sets the pace. A palette write takes one serializer slot and no pixel.
// Pipeline: serializer, palette lookup, color register, level map into the output register.
// Reset clears all valid bits and the palette to zero.
// out_stall holds every stage that has a successor waiting; bubbles are filled.

module bitplane_palette_pixel_converter #(
  parameter int PIXELS_PER_WORD = bppc_pkg::PIXELS_PER_WORD
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_mode,
  input  wire logic [bppc_pkg::INDEX_BITS-1:0] in_palette_index,
  input  wire logic [bppc_pkg::COLOR_BITS-1:0] in_palette_word,
  input  wire logic [bppc_pkg::PLANE_BITS-1:0] in_plane_zero,
  input  wire logic [bppc_pkg::PLANE_BITS-1:0] in_plane_one,
  input  wire logic [bppc_pkg::PLANE_BITS-1:0] in_plane_two,
  input  wire logic [bppc_pkg::PLANE_BITS-1:0] in_plane_three,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [7:0]                         out_red,
  output logic [7:0]                         out_green,
  output logic [7:0]                         out_blue,
  output logic                               out_last_pixel
);
  import bppc_pkg::*;

  logic       s0_valid;
  bppc_slot_t s0_slot;

  logic       s1_valid_r;
  bppc_slot_t s1_slot_r;

  logic                  s2_valid_r;
  logic [COLOR_BITS-1:0] s2_color_r;
  logic                  s2_last_r;

  logic                  out_valid_r;
  logic [7:0]            out_red_r, out_green_r, out_blue_r;
  logic                  out_last_r;

  logic [COLOR_BITS-1:0] palette_r [PALETTE_ENTRIES];

  logic adv1, adv2, adv3;

  assign adv3 = !out_valid_r || !out_stall;
  assign adv2 = !s2_valid_r || adv3;
  assign adv1 = !s1_valid_r || adv2;

  bppc_plane_serializer #(
    .PIXELS_PER_WORD(PIXELS_PER_WORD)
  ) u_ser (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_palette_index(in_palette_index),
    .in_palette_word (in_palette_word),
    .in_plane_zero   (in_plane_zero),
    .in_plane_one    (in_plane_one),
    .in_plane_two    (in_plane_two),
    .in_plane_three  (in_plane_three),
    .take            (adv1),
    .slot_valid      (s0_valid),
    .slot            (s0_slot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv1) begin
      s1_valid_r <= s0_valid;
      s1_slot_r  <= s0_slot;
    end
  end

  // palette writes land in slot order, so earlier pixels already read old entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
        palette_r[i] <= '0;
      end
    end else if (s1_valid_r && s1_slot_r.write && adv2) begin
      palette_r[s1_slot_r.idx] <= s1_slot_r.word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv2) begin
      s2_valid_r <= s1_valid_r && !s1_slot_r.write;
      s2_color_r <= palette_r[s1_slot_r.idx];
      s2_last_r  <= s1_slot_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv3) begin
      out_valid_r <= s2_valid_r;
      out_red_r   <= nibble_level(s2_color_r[3:0]);
      out_green_r <= nibble_level(s2_color_r[7:4]);
      out_blue_r  <= nibble_level(s2_color_r[11:8]);
      out_last_r  <= s2_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red        = out_red_r;
  assign out_green      = out_green_r;
  assign out_blue       = out_blue_r;
  assign out_last_pixel = out_last_r;

`ifndef SYNTHESIS
  // a taken plane group keeps the serializer busy and stalls the input
  a_plane_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_mode == MODE_PLANES) |=> in_stall)
    else $error("input taken during a plane group");

  // groups have PIXELS_PER_WORD pixels, so two last pixels never follow each other
  a_last_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_pixel) |=> !(out_valid && out_last_pixel))
    else $error("back-to-back last pixels");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s0_valid |-> !in_stall)
    else $error("stall with an empty serializer");

  a_red_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_red == 8'd0 || out_red == 8'd127 ||
                   out_red == 8'd191 || out_red == 8'd255))
    else $error("red level out of set");
`endif

endmodule

`default_nettype wire

### design/bppc_plane_serializer.sv
`default_nettype none

module bppc_plane_serializer #(
  parameter int PIXELS_PER_WORD = bppc_pkg::PIXELS_PER_WORD
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_mode,
  input  wire logic [bppc_pkg::INDEX_BITS-1:0] in_palette_index,
  input  wire logic [bppc_pkg::COLOR_BITS-1:0] in_palette_word,
  input  wire logic [bppc_pkg::PLANE_BITS-1:0] in_plane_zero,
  input  wire logic [bppc_pkg::PLANE_BITS-1:0] in_plane_one,
  input  wire logic [bppc_pkg::PLANE_BITS-1:0] in_plane_two,
  input  wire logic [bppc_pkg::PLANE_BITS-1:0] in_plane_three,
  input  wire logic                          take,
  output logic                               slot_valid,
  output bppc_pkg::bppc_slot_t               slot
);
  import bppc_pkg::*;

  localparam int CNT_W = $clog2(PIXELS_PER_WORD);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(PIXELS_PER_WORD - 1);

  logic                  valid_r;
  logic                  write_r;
  logic [INDEX_BITS-1:0] pidx_r;
  logic [COLOR_BITS-1:0] pword_r;
  logic [PLANE_BITS-1:0] p0_r, p1_r, p2_r, p3_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [CNT_W-1:0]      cnt_nxt;
  logic                  done;
  logic                  accept;

  assign done     = write_r || (cnt_r == LAST_CNT);
  assign in_stall = valid_r && !(take && done);
  assign accept   = in_valid && !in_stall;
  assign cnt_nxt  = cnt_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
      write_r <= (in_mode == MODE_PALETTE);
      pidx_r  <= in_palette_index;
      pword_r <= in_palette_word;
      p0_r    <= in_plane_zero;
      p1_r    <= in_plane_one;
      p2_r    <= in_plane_two;
      p3_r    <= in_plane_three;
      cnt_r   <= '0;
    end else if (take && valid_r) begin
      if (done) begin
        valid_r <= 1'b0;
      end else begin
        // zero fill: pixels past the plane width use palette entry 0
        p0_r  <= p0_r >> 1;
        p1_r  <= p1_r >> 1;
        p2_r  <= p2_r >> 1;
        p3_r  <= p3_r >> 1;
        cnt_r <= cnt_nxt;
      end
    end
  end

  assign slot_valid = valid_r;
  assign slot.write = write_r;
  assign slot.idx   = write_r ? pidx_r : {p3_r[0], p2_r[0], p1_r[0], p0_r[0]};
  assign slot.word  = pword_r;
  assign slot.last  = !write_r && (cnt_r == LAST_CNT);

endmodule

`default_nettype wire

### dv/bitplane_palette_pixel_converter_tb.sv
module bitplane_palette_pixel_converter_tb;
  import bppc_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

  // one row of the directed table; uniform rows carry one color for every pixel
  typedef struct packed {
    logic                  mode;
    logic [INDEX_BITS-1:0] idx;
    logic [COLOR_BITS-1:0] word;
    logic [PLANE_BITS-1:0] p0;
    logic [PLANE_BITS-1:0] p1;
    logic [PLANE_BITS-1:0] p2;
    logic [PLANE_BITS-1:0] p3;
    logic                  uniform;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 19;
  localparam int RANDOM_ITEMS  = 480;
  localparam int HOLD_CYCLES   = 400;
  localparam int MAX_REPORTS   = 20;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_mode;
  logic [INDEX_BITS-1:0] in_palette_index;
  logic [COLOR_BITS-1:0] in_palette_word;
  logic [PLANE_BITS-1:0] in_plane_zero;
  logic [PLANE_BITS-1:0] in_plane_one;
  logic [PLANE_BITS-1:0] in_plane_two;
  logic [PLANE_BITS-1:0] in_plane_three;
  logic                  out_valid;
  logic                  out_stall;
  logic [7:0]            out_red;
  logic [7:0]            out_green;
  logic [7:0]            out_blue;
  logic                  out_last_pixel;

  logic [COLOR_BITS-1:0] palette_model [PALETTE_ENTRIES];
  pixel_t                pixel_q [$];
  pixel_t                head_px;
  stim_row_t             dir_rows [DIRECTED_ROWS];

  int  fail_count;
  int  report_count;
  int  writes_sent;
  int  groups_sent;
  int  pixels_checked;
  int  in_stall_cycles;
  bit  hold_req;

  bitplane_palette_pixel_converter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_palette_index (in_palette_index),
    .in_palette_word  (in_palette_word),
    .in_plane_zero    (in_plane_zero),
    .in_plane_one     (in_plane_one),
    .in_plane_two     (in_plane_two),
    .in_plane_three   (in_plane_three),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_last_pixel   (out_last_pixel)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("bitplane_palette_pixel_converter_tb NOT OK");
    $finish;
  end

  // nibble is bit-reversed and inverted; its top two bits pick the level
  function automatic logic [7:0] level_of(input logic [3:0] nib);
    logic [3:0] flip;
    int         lvl;
    flip = ~{nib[0], nib[1], nib[2], nib[3]};
    lvl  = int'(flip[3:2]);
    if (lvl == 0) return 8'd0;
    return 8'((lvl + 1) * 64 - 1);
  endfunction

  function automatic logic [PLANE_BITS-1:0] plane_pattern();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 32'h1 << $urandom_range(0, PLANE_BITS - 1);
      3: return ~(32'h1 << $urandom_range(0, PLANE_BITS - 1));
      default: return $urandom();
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // works out the pixels of one group from the palette as it stands now
  task automatic predict_pixels(input stim_row_t row);
    logic [INDEX_BITS-1:0] pix_idx;
    logic [COLOR_BITS-1:0] color;
    pixel_t                px;
    for (int j = 0; j < PIXELS_PER_WORD; j++) begin
      pix_idx = '0;
      if (j < PLANE_BITS) pix_idx = {row.p3[j], row.p2[j], row.p1[j], row.p0[j]};
      color    = palette_model[pix_idx];
      px.red   = level_of(color[3:0]);
      px.green = level_of(color[7:4]);
      px.blue  = level_of(color[11:8]);
      if (row.uniform) begin
        px.red   = row.red;
        px.green = row.green;
        px.blue  = row.blue;
      end
      px.last = (j == PIXELS_PER_WORD - 1);
      pixel_q.push_back(px);
    end
  endtask

  task automatic send_item(input int gap, input stim_row_t row);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid         = 1'b1;
    in_mode          = row.mode;
    in_palette_index = row.idx;
    in_palette_word  = row.word;
    in_plane_zero    = row.p0;
    in_plane_one     = row.p1;
    in_plane_two     = row.p2;
    in_plane_three   = row.p3;
    do begin
      @(posedge clk);
      if (in_stall) in_stall_cycles++;
    end while (in_stall);
    // transfer taken at this edge
    if (row.mode == MODE_PALETTE) begin
      palette_model[row.idx] = row.word;
      writes_sent++;
    end else begin
      predict_pixels(row);
      groups_sent++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_q.size() == 0) begin
        fail_count++;
        if (report_count++ < MAX_REPORTS)
          $display("%0t: pixel with nothing expected: r=%0d g=%0d b=%0d last=%0b",
                   $time, out_red, out_green, out_blue, out_last_pixel);
      end else begin
        head_px = pixel_q.pop_front();
        pixels_checked++;
        if (out_red !== head_px.red || out_green !== head_px.green ||
            out_blue !== head_px.blue || out_last_pixel !== head_px.last) begin
          fail_count++;
          if (report_count++ < MAX_REPORTS)
            $display({"%0t: pixel mismatch: expected r=%0d g=%0d b=%0d last=%0b,",
                      " got r=%0d g=%0d b=%0d last=%0b"},
                     $time, head_px.red, head_px.green, head_px.blue, head_px.last,
                     out_red, out_green, out_blue, out_last_pixel);
        end
      end
    end
  end

  // receiver: stretches of free flow, random stalls and full stalls
  initial begin
    int seg;
    int len;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        for (int i = 0; i < HOLD_CYCLES; i++) begin
          @(negedge clk);
          out_stall = 1'b1;
        end
      end
      seg = $urandom_range(0, 9);
      len = $urandom_range(8, 80);
      for (int i = 0; i < len; i++) begin
        @(negedge clk);
        case (seg)
          0, 1, 2, 3: out_stall = 1'b0;
          4, 5, 6, 7: out_stall = ($urandom_range(0, 3) == 0);
          8:          out_stall = 1'($urandom_range(0, 1));
          default:    out_stall = 1'b1;
        endcase
      end
    end
  end

  initial begin
    stim_row_t row;
    int        gap;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_mode          = MODE_PALETTE;
    in_palette_index = '0;
    in_palette_word  = '0;
    in_plane_zero    = '0;
    in_plane_one     = '0;
    in_plane_two     = '0;
    in_plane_three   = '0;
    hold_req         = 1'b0;
    fail_count       = 0;
    report_count     = 0;
    writes_sent      = 0;
    groups_sent      = 0;
    pixels_checked   = 0;
    in_stall_cycles  = 0;
    for (int i = 0; i < PALETTE_ENTRIES; i++) palette_model[i] = '0;

    // palette all zero after reset: nibble 0 maps to full level
    dir_rows[0]  = '{MODE_PLANES, 4'h0, 12'h000, '0, '0, '0, '0, 1'b1, 8'd255, 8'd255, 8'd255};
    dir_rows[1]  = '{MODE_PLANES, 4'h0, 12'h000, '1, '1, '1, '1, 1'b1, 8'd255, 8'd255, 8'd255};
    // writes ignore the plane words
    dir_rows[2]  = '{MODE_PALETTE, 4'h0, 12'hFFF, '1, '1, '1, '1, 1'b0, 8'd0, 8'd0, 8'd0};
    dir_rows[3]  = '{MODE_PALETTE, 4'hF, 12'h000, '0, '0, '0, '0, 1'b0, 8'd0, 8'd0, 8'd0};
    // groups ignore the palette fields; nibble F maps to zero
    dir_rows[4]  = '{MODE_PLANES, 4'hF, 12'hABC, '0, '0, '0, '0, 1'b1, 8'd0, 8'd0, 8'd0};
    dir_rows[5]  = '{MODE_PLANES, 4'h0, 12'h000, '1, '1, '1, '1, 1'b1, 8'd255, 8'd255, 8'd255};
    dir_rows[6]  = '{MODE_PALETTE, 4'h1, 12'h0F0, 32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F,
                     32'h55AA55AA, 1'b0, 8'd0, 8'd0, 8'd0};
    dir_rows[7]  = '{MODE_PALETTE, 4'h2, 12'h842, '0, '0, '0, '0, 1'b0, 8'd0, 8'd0, 8'd0};
    dir_rows[8]  = '{MODE_PALETTE, 4'h4, 12'h1E7, '0, '0, '0, '0, 1'b0, 8'd0, 8'd0, 8'd0};
    dir_rows[9]  = '{MODE_PALETTE, 4'h8, 12'hC39, '0, '0, '0, '0, 1'b0, 8'd0, 8'd0, 8'd0};
    dir_rows[10] = '{MODE_PALETTE, 4'h7, 12'h5B6, '0, '0, '0, '0, 1'b0, 8'd0, 8'd0, 8'd0};
    dir_rows[11] = '{MODE_PLANES, 4'h0, 12'h000, 32'hAAAAAAAA, 32'hCCCCCCCC, 32'hF0F0F0F0,
                     32'hFF00FF00, 1'b0, 8'd0, 8'd0, 8'd0};
    // one plane bit at a time, first pixel, last pixel and the middle
    dir_rows[12] = '{MODE_PLANES, 4'h0, 12'h000, 32'h00000001, '0, '0, '0, 1'b0, 8'd0, 8'd0, 8'd0};
    dir_rows[13] = '{MODE_PLANES, 4'h0, 12'h000, '0, 32'h80000000, '0, '0, 1'b0, 8'd0, 8'd0, 8'd0};
    dir_rows[14] = '{MODE_PLANES, 4'h0, 12'h000, '0, '0, 32'h00010000, '0, 1'b0, 8'd0, 8'd0, 8'd0};
    dir_rows[15] = '{MODE_PLANES, 4'h0, 12'h000, '0, '0, '0, 32'h00008000, 1'b0, 8'd0, 8'd0, 8'd0};
    dir_rows[16] = '{MODE_PLANES, 4'h0, 12'h000, '1, '1, '1, '0, 1'b0, 8'd0, 8'd0, 8'd0};
    dir_rows[17] = '{MODE_PALETTE, 4'hF, 12'hFFF, 32'h5A5A5A5A, 32'hA5A5A5A5, '1, '1,
                     1'b0, 8'd0, 8'd0, 8'd0};
    dir_rows[18] = '{MODE_PLANES, 4'h0, 12'h000, '1, '1, '1, '1, 1'b1, 8'd0, 8'd0, 8'd0};

    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    for (int k = 0; k < DIRECTED_ROWS; k++) send_item(pick_gap(), dir_rows[k]);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      row.mode    = ($urandom_range(0, 3) == 0) ? MODE_PALETTE : MODE_PLANES;
      row.idx     = INDEX_BITS'($urandom_range(0, PALETTE_ENTRIES - 1));
      row.word    = COLOR_BITS'($urandom());
      row.p0      = plane_pattern();
      row.p1      = plane_pattern();
      row.p2      = plane_pattern();
      row.p3      = plane_pattern();
      row.uniform = 1'b0;
      row.red     = '0;
      row.green   = '0;
      row.blue    = '0;
      // long receiver hold-off while the sender keeps offering back to back
      if (k == 150) hold_req = 1'b1;
      gap = pick_gap();
      if ((k >= 150 && k < 200) || (k % 97) < 15) gap = 0;
      send_item(gap, row);
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("covered %0d palette writes and %0d plane groups, %0d pixels compared",
             writes_sent, groups_sent, pixels_checked);
    $display("input held off for %0d cycles while a transfer was offered", in_stall_cycles);
    if (fail_count == 0) begin
      $display("bitplane_palette_pixel_converter_tb OK");
    end else begin
      $display("bitplane_palette_pixel_converter_tb NOT OK");
    end
    $finish;
  end

endmodule
